### hw/rtl/sbt_pkg.sv
`timescale 1ns / 1ps

package sbt_pkg;

	// Datapath widths that follow from the fixed 16-bit coordinate fields.
	localparam int CoordW = 16;
	localparam int DiffW  = CoordW + 1;
	localparam int FracW  = 14;
	localparam int VecW   = 34;
	localparam int ZW     = 32;
	localparam int StepW  = 15;
	localparam int TabLen = 24;
	localparam int TabIdxW = 5;

	// Configuration register indexes.
	localparam logic [7:0] REG_PIVOT_X  = 8'd0;
	localparam logic [7:0] REG_PIVOT_Y  = 8'd1;
	localparam logic [7:0] REG_MIRRORED = 8'd2;
	localparam logic [7:0] REG_MAX_STEP = 8'd3;

	typedef struct packed {
		logic signed [CoordW-1:0] pivot_x;
		logic signed [CoordW-1:0] pivot_y;
		logic                     mirrored;
		logic [StepW-1:0]         max_step;
	} sbt_cfg_t;

	// One classified tick as it waits between the front and the back.
	typedef struct packed {
		logic                   tgt;
		logic                   zero;
		logic                   mir;
		logic signed [VecW-1:0] x0;
		logic signed [VecW-1:0] y0;
		logic [ZW-1:0]          z0;
	} sbt_item_t;

	// Arctangent of 2^-i, 2^32 units per turn, rounded to nearest.
	function automatic logic [ZW-1:0] sbt_atan(input logic [TabIdxW-1:0] idx);
		logic [ZW-1:0] v;
		case (idx)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

### hw/rtl/sbt_front.sv
`timescale 1ns / 1ps

module sbt_front import sbt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sbt_cfg_t                 cfg,
	input  logic                     push,
	output logic                     full,
	input  logic                     target_valid,
	input  logic signed [CoordW-1:0] target_x,
	input  logic signed [CoordW-1:0] target_y,
	output logic                     item_valid,
	output sbt_item_t                item,
	input  logic                     item_pop
);

	logic signed [DiffW-1:0] dx;
	logic signed [DiffW-1:0] dy_raw;
	logic signed [DiffW-1:0] dy;
	logic signed [VecW-1:0]  xs;
	logic signed [VecW-1:0]  ys;
	sbt_item_t               cls;
	sbt_item_t               mem_q [2];
	logic                    wr_ptr_q;
	logic                    rd_ptr_q;
	logic [1:0]              cnt_q;
	logic                    wr_en;
	logic                    rd_en;

	// Offsets from the pivot, with the y offset negated in mirrored mode.
	assign dx     = {target_x[CoordW-1], target_x} - {cfg.pivot_x[CoordW-1], cfg.pivot_x};
	assign dy_raw = {target_y[CoordW-1], target_y} - {cfg.pivot_y[CoordW-1], cfg.pivot_y};
	assign dy     = cfg.mirrored ? -dy_raw : dy_raw;
	assign xs     = {{(VecW-DiffW-FracW){dx[DiffW-1]}}, dx, {FracW{1'b0}}};
	assign ys     = {{(VecW-DiffW-FracW){dy[DiffW-1]}}, dy, {FracW{1'b0}}};

	// Classify the tick and fold the left half plane over by half a turn.
	always_comb begin
		cls.tgt  = target_valid;
		cls.zero = (dx == '0) && (dy == '0);
		cls.mir  = cfg.mirrored;
		if (dx[DiffW-1]) begin
			cls.x0 = -xs;
			cls.y0 = -ys;
			cls.z0 = 32'h8000_0000;
		end else begin
			cls.x0 = xs;
			cls.y0 = ys;
			cls.z0 = '0;
		end
	end

	assign full       = cnt_q[1];
	assign wr_en      = push && !full;
	assign item_valid = (cnt_q != 2'd0);
	assign rd_en      = item_pop && item_valid;
	assign item       = mem_q[rd_ptr_q];

	// Two-entry queue storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

### hw/rtl/sbt_back.sv
`timescale 1ns / 1ps

module sbt_back import sbt_pkg::*; #(
	parameter int ANGLE_BITS        = 16,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [StepW-1:0]      max_step,
	input  logic                  item_valid,
	input  sbt_item_t             item,
	output logic                  item_pop,
	input  logic                  pop,
	output logic                  empty,
	output logic [ANGLE_BITS-1:0] heading,
	output logic                  on_bearing
);

	localparam int NIt  = (CORDIC_ITERATIONS > TabLen) ? TabLen : CORDIC_ITERATIONS;
	localparam int CntW = $clog2(NIt);
	localparam int MagW = (ANGLE_BITS > StepW) ? ANGLE_BITS : StepW;
	localparam logic [CntW-1:0]       LastIt = CntW'(NIt - 1);
	localparam logic [ZW-1:0]         Rnd    = 32'd1 << (31 - ANGLE_BITS);
	localparam logic [ANGLE_BITS-1:0] Half   = {1'b1, {(ANGLE_BITS-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} sbt_state_t;

	sbt_state_t              st_q;
	logic [CntW-1:0]         it_q;
	logic signed [VecW-1:0]  x_q;
	logic signed [VecW-1:0]  y_q;
	logic [ZW-1:0]           z_q;
	logic                    tgt_q;
	logic                    mir_q;
	logic [ANGLE_BITS-1:0]   head_q;
	logic                    res_valid_q;
	logic [ANGLE_BITS-1:0]   res_head_q;
	logic                    res_on_q;
	logic signed [VecW-1:0]  x_sh;
	logic signed [VecW-1:0]  y_sh;
	logic [ZW-1:0]           z_rnd;
	logic [ANGLE_BITS-1:0]   brg_raw;
	logic [ANGLE_BITS-1:0]   brg;
	logic [ANGLE_BITS-1:0]   err;
	logic [ANGLE_BITS-1:0]   mag;
	logic                    up;
	logic [MagW-1:0]         step_w;
	logic [ANGLE_BITS-1:0]   step;
	logic                    snap;
	logic [ANGLE_BITS-1:0]   head_nx;
	logic                    res_free;
	logic                    fin_go;

	assign item_pop = (st_q == ST_IDLE) && item_valid;
	assign res_free = !res_valid_q || pop;
	assign fin_go   = (st_q == ST_FIN) && res_free;

	// Shared CORDIC shifters.
	assign x_sh = x_q >>> it_q;
	assign y_sh = y_q >>> it_q;

	// Bearing rounding, error wrap and slew step.
	always_comb begin
		z_rnd   = z_q + Rnd;
		brg_raw = z_rnd[ZW-1 -: ANGLE_BITS];
		brg     = mir_q ? (Half - brg_raw) : brg_raw;
		err     = brg - head_q;
		up      = (err <= Half);
		mag     = up ? err : -err;
		step_w  = MagW'(max_step);
		step    = step_w[ANGLE_BITS-1:0];
		snap    = (MagW'(mag) <= step_w);
		if (!tgt_q) begin
			head_nx = head_q;
		end else if (snap) begin
			head_nx = brg;
		end else if (up) begin
			head_nx = head_q + step;
		end else begin
			head_nx = head_q - step;
		end
	end

	// Sequencer and heading state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			it_q        <= '0;
			head_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// The result register is refilled by a finished tick and emptied by a pop.
			if (fin_go) begin
				res_valid_q <= 1'b1;
			end else if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (item_valid) begin
						it_q <= '0;
						st_q <= (item.tgt && !item.zero) ? ST_RUN : ST_FIN;
					end
				end
				ST_RUN: begin
					it_q <= it_q + CntW'(1);
					if (it_q == LastIt) begin
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (res_free) begin
						head_q <= head_nx;
						st_q   <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Vectoring iterations and result payload.
	always_ff @(posedge clk) begin
		if (item_pop) begin
			x_q   <= item.x0;
			y_q   <= item.y0;
			z_q   <= item.z0;
			tgt_q <= item.tgt;
			mir_q <= item.mir;
		end else if (st_q == ST_RUN) begin
			if (y_q > 0) begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + sbt_atan(TabIdxW'(it_q));
			end else begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - sbt_atan(TabIdxW'(it_q));
			end
		end
		if (fin_go) begin
			res_head_q <= head_nx;
			res_on_q   <= tgt_q && snap;
		end
	end

	assign empty      = !res_valid_q;
	assign heading    = res_head_q;
	assign on_bearing = res_on_q;

	// A waiting result is never overwritten.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !pop |=> res_valid_q && $stable(res_head_q))
		else $error("waiting result changed before it was taken");

	// The heading moves only when a result is written.
	a_head_fin: assert property (@(posedge clk) disable iff (!arst_n)
		!fin_go |=> $stable(head_q))
		else $error("heading changed outside the finish step");

	// A new tick is taken from the queue only while the sequencer is idle.
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |=> (st_q == ST_RUN) || (st_q == ST_FIN))
		else $error("tick taken but sequencer did not start");

	// The iteration counter stays inside the table while running.
	a_it_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RUN) |-> (it_q <= LastIt))
		else $error("iteration counter out of range");

endmodule

### hw/rtl/slew_limited_bearing_tracker.sv
`timescale 1ns / 1ps

// Slew-limited bearing tracker. Each pushed tick either holds the heading (no
// target) or turns it toward the bearing from the configured pivot to the
// target, found by a vectoring CORDIC atan2, by at most max_step units; when
// the bearing is within max_step the heading snaps to it and on_bearing is
// set. One result comes out per tick, in order. A two-entry queue after the
// offset and classify front lets ticks be pushed while the back works and
// while a result waits to be popped. In the back, a tick with a target away
// from the pivot runs CORDIC_ITERATIONS iterations (capped at the table
// length) in the single shared CORDIC iteration stage; a tick without a
// target, or with the target on the pivot, skips them and goes to its finish.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data
// and are always ready; write them only while no tick is in flight.
module slew_limited_bearing_tracker import sbt_pkg::*; #(
	parameter int ANGLE_BITS        = 16,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [7:0]               cfg_index,
	input  logic [CoordW-1:0]        cfg_data,
	input  logic                     push,
	output logic                     full,
	input  logic                     target_valid,
	input  logic signed [CoordW-1:0] target_x,
	input  logic signed [CoordW-1:0] target_y,
	input  logic                     pop,
	output logic                     empty,
	output logic [ANGLE_BITS-1:0]    heading,
	output logic                     on_bearing
);

	sbt_cfg_t  cfg_q;
	sbt_item_t item;
	logic      item_valid;
	logic      item_pop;

	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pivot_x  <= '0;
			cfg_q.pivot_y  <= '0;
			cfg_q.mirrored <= 1'b0;
			cfg_q.max_step <= 15'd364;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PIVOT_X:  cfg_q.pivot_x  <= cfg_data;
				REG_PIVOT_Y:  cfg_q.pivot_y  <= cfg_data;
				REG_MIRRORED: cfg_q.mirrored <= cfg_data[0];
				REG_MAX_STEP: cfg_q.max_step <= cfg_data[StepW-1:0];
				default: begin
				end
			endcase
		end
	end

	sbt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.push         (push),
		.full         (full),
		.target_valid (target_valid),
		.target_x     (target_x),
		.target_y     (target_y),
		.item_valid   (item_valid),
		.item         (item),
		.item_pop     (item_pop)
	);

	sbt_back #(
		.ANGLE_BITS        (ANGLE_BITS),
		.CORDIC_ITERATIONS (CORDIC_ITERATIONS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.max_step   (cfg_q.max_step),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.pop        (pop),
		.empty      (empty),
		.heading    (heading),
		.on_bearing (on_bearing)
	);

endmodule
